### design/rbnh_pkg.sv
`timescale 1ns / 1ps
package rbnh_pkg;

   localparam int MAX_BOXES = 64;
   localparam int IDX_W     = $clog2(MAX_BOXES);
   localparam int CNT_W     = $clog2(MAX_BOXES + 1);
   localparam int Q_W       = 24;
   localparam int DIST_W    = 23;
   localparam int NUM_W     = Q_W + 1 + 12;

   localparam logic REQ_WRITE = 1'b0;
   localparam logic REQ_QUERY = 1'b1;

   localparam logic CSR_OBSTACLE_COUNT = 1'b0;
   localparam logic CSR_MAX_DISTANCE   = 1'b1;

   localparam logic [DIST_W-1:0] MAX_DISTANCE_RESET = 23'd4096000;

   typedef struct packed {
      logic                   req_type;
      logic [5:0]             entry_index;
      logic signed [Q_W-1:0]  pos_x;
      logic signed [Q_W-1:0]  pos_y;
      logic signed [Q_W-1:0]  pos_z;
      logic signed [Q_W-1:0]  vec_x;
      logic signed [Q_W-1:0]  vec_y;
      logic signed [Q_W-1:0]  vec_z;
   } req_item_type;

   typedef struct packed {
      logic [DIST_W-1:0] hit_distance;
      logic              hit_found;
   } rsp_item_type;

   typedef struct packed {
      logic             wr_en;
      logic             q_load;
      logic             rd_en;
      logic [IDX_W-1:0] rd_addr;
      logic             div_start;
      logic             eval;
      logic             out_load;
   } cmd_type;

   typedef struct packed {
      logic div_busy;
   } status_type;

   // saturate a 25-bit signed sum to the 24-bit signed range
   function automatic logic signed [Q_W-1:0] sat24(input logic signed [Q_W:0] v);
      logic signed [Q_W-1:0] r;
      if (v[Q_W] != v[Q_W-1]) begin
         r = v[Q_W] ? {1'b1, {(Q_W-1){1'b0}}} : {1'b0, {(Q_W-1){1'b1}}};
      end else begin
         r = v[Q_W-1:0];
      end
      return r;
   endfunction

endpackage

### design/rbnh_div.sv
`timescale 1ns / 1ps
module rbnh_div (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic signed [rbnh_pkg::NUM_W-1:0]   num,
   input  logic signed [rbnh_pkg::Q_W-1:0]     den,
   output logic                                busy,
   output logic signed [rbnh_pkg::Q_W-1:0]     quot
);
   localparam int NW = rbnh_pkg::NUM_W;
   localparam int QW = rbnh_pkg::Q_W;
   localparam int SW = 2 * QW;
   localparam logic [4:0] FIRST = 5'(QW + 2);

   logic              busy_ff, busy_in;
   logic [4:0]        cnt_ff, cnt_in;
   logic [NW-1:0]     rem_ff, rem_in;
   logic [QW-1:0]     den_ff, den_in;
   logic [SW-1:0]     dsh_ff, dsh_in;
   logic [QW:0]       q_ff, q_in;
   logic              neg_ff, neg_in;
   logic              ovf_ff, ovf_in;
   logic              take;

   assign take = {{(SW-NW){1'b0}}, rem_ff} >= dsh_ff;

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      dsh_in  = dsh_ff;
      q_in    = q_ff;
      neg_in  = neg_ff;
      ovf_in  = ovf_ff;
      if (start) begin
         rem_in  = num[NW-1] ? NW'(-num) : NW'(num);
         den_in  = den[QW-1] ? QW'(-den) : QW'(den);
         neg_in  = num[NW-1] ^ den[QW-1];
         cnt_in  = FIRST;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         cnt_in = cnt_ff - 5'd1;
         if (cnt_ff == FIRST) begin
            // quotient of 2^25 or more saturates whatever the sign
            ovf_in = {{(QW+1+1){1'b0}}, rem_ff} >= {den_ff, {(QW+1){1'b0}}};
            dsh_in = {den_ff, {QW{1'b0}}};
            q_in   = '0;
         end else begin
            if (take) begin
               rem_in = rem_ff - dsh_ff[NW-1:0];
            end
            q_in   = {q_ff[QW-1:0], take};
            dsh_in = dsh_ff >> 1;
            if (cnt_ff == 5'd1) begin
               busy_in = 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      den_ff <= den_in;
      dsh_ff <= dsh_in;
      q_ff   <= q_in;
      neg_ff <= neg_in;
      ovf_ff <= ovf_in;
   end

   always_comb begin
      if (neg_ff) begin
         if (ovf_ff || q_ff > {1'b0, 1'b1, {(QW-1){1'b0}}}) begin
            quot = {1'b1, {(QW-1){1'b0}}};
         end else begin
            quot = -q_ff[QW-1:0];
         end
      end else begin
         if (ovf_ff || q_ff > {2'b00, {(QW-1){1'b1}}}) begin
            quot = {1'b0, {(QW-1){1'b1}}};
         end else begin
            quot = q_ff[QW-1:0];
         end
      end
   end

   assign busy = busy_ff;

endmodule

### design/rbnh_datapath.sv
`timescale 1ns / 1ps
module rbnh_datapath (
   input  logic                              clock,
   input  logic                              reset,
   input  rbnh_pkg::cmd_type                 cmd,
   input  rbnh_pkg::req_item_type            req_data,
   input  logic [rbnh_pkg::DIST_W-1:0]       max_distance,
   output rbnh_pkg::status_type              status,
   output rbnh_pkg::rsp_item_type            rsp_data
);
   localparam int QW = rbnh_pkg::Q_W;
   localparam int NW = rbnh_pkg::NUM_W;

   logic signed [QW-1:0] min_x_mem [rbnh_pkg::MAX_BOXES];
   logic signed [QW-1:0] max_x_mem [rbnh_pkg::MAX_BOXES];
   logic signed [QW-1:0] min_z_mem [rbnh_pkg::MAX_BOXES];
   logic signed [QW-1:0] max_z_mem [rbnh_pkg::MAX_BOXES];
   logic signed [QW-1:0] top_y_mem [rbnh_pkg::MAX_BOXES];

   logic signed [QW-1:0] lo_x_ff, hi_x_ff, lo_z_ff, hi_z_ff, hi_y_ff;
   logic signed [QW-1:0] ox_ff, oy_ff, oz_ff, dx_ff, dy_ff, dz_ff;
   logic signed [QW-1:0] best_ff, best_in;
   rbnh_pkg::rsp_item_type rsp_ff;

   logic signed [NW-1:0] num [6];
   logic signed [QW-1:0] den [3];
   logic signed [QW-1:0] quot [6];
   logic                 busy [6];

   logic signed [QW-1:0] lo [3];
   logic signed [QW-1:0] hi [3];
   logic signed [QW-1:0] o  [3];

   logic [rbnh_pkg::IDX_W-1:0] wr_addr;

   assign wr_addr = req_data.entry_index[rbnh_pkg::IDX_W-1:0];

   // table write and registered read
   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         min_x_mem[wr_addr] <= rbnh_pkg::sat24(25'(req_data.pos_x) - 25'(req_data.vec_x));
         max_x_mem[wr_addr] <= rbnh_pkg::sat24(25'(req_data.pos_x) + 25'(req_data.vec_x));
         min_z_mem[wr_addr] <= rbnh_pkg::sat24(25'(req_data.pos_z) - 25'(req_data.vec_z));
         max_z_mem[wr_addr] <= rbnh_pkg::sat24(25'(req_data.pos_z) + 25'(req_data.vec_z));
         top_y_mem[wr_addr] <= req_data.vec_y;
      end
      if (cmd.rd_en) begin
         lo_x_ff <= min_x_mem[cmd.rd_addr];
         hi_x_ff <= max_x_mem[cmd.rd_addr];
         lo_z_ff <= min_z_mem[cmd.rd_addr];
         hi_z_ff <= max_z_mem[cmd.rd_addr];
         hi_y_ff <= top_y_mem[cmd.rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.q_load) begin
         ox_ff <= req_data.pos_x;
         oy_ff <= req_data.pos_y;
         oz_ff <= req_data.pos_z;
         dx_ff <= req_data.vec_x;
         dy_ff <= req_data.vec_y;
         dz_ff <= req_data.vec_z;
      end
      best_ff <= best_in;
      if (cmd.out_load) begin
         rsp_ff.hit_distance <= best_ff[rbnh_pkg::DIST_W-1:0];
         rsp_ff.hit_found    <= best_ff < $signed({1'b0, max_distance});
      end
   end

   assign lo[0] = lo_x_ff;  assign hi[0] = hi_x_ff;  assign o[0] = ox_ff;  assign den[0] = dx_ff;
   assign lo[1] = '0;       assign hi[1] = hi_y_ff;  assign o[1] = oy_ff;  assign den[1] = dy_ff;
   assign lo[2] = lo_z_ff;  assign hi[2] = hi_z_ff;  assign o[2] = oz_ff;  assign den[2] = dz_ff;

   // slab numerators: (bound - origin) scaled by one Q12.12 unit
   always_comb begin
      for (int a = 0; a < 3; a++) begin
         num[2*a]   = {(25'(lo[a]) - 25'(o[a])), 12'b0};
         num[2*a+1] = {(25'(hi[a]) - 25'(o[a])), 12'b0};
      end
   end

   for (genvar g = 0; g < 6; g++) begin : g_div
      rbnh_div u_div (
         .clock (clock),
         .reset (reset),
         .start (cmd.div_start),
         .num   (num[g]),
         .den   (den[g/2]),
         .busy  (busy[g]),
         .quot  (quot[g])
      );
   end

   assign status.div_busy = busy[0] | busy[1] | busy[2] | busy[3] | busy[4] | busy[5];

   // slab intersection of the current box and best-distance update
   always_comb begin
      logic signed [QW-1:0] tnear, tfar, tmin, tmax;
      logic                 miss;
      tnear   = '0;
      tfar    = $signed({1'b0, max_distance});
      tmin    = '0;
      tmax    = '0;
      miss    = 1'b0;
      best_in = best_ff;
      for (int a = 0; a < 3; a++) begin
         if (den[a] == '0) begin
            if (o[a] < lo[a] || o[a] > hi[a]) begin
               miss = 1'b1;
            end
         end else begin
            tmin = (quot[2*a] > quot[2*a+1]) ? quot[2*a+1] : quot[2*a];
            tmax = (quot[2*a] > quot[2*a+1]) ? quot[2*a] : quot[2*a+1];
            if (tmin > tnear) tnear = tmin;
            if (tmax < tfar)  tfar  = tmax;
         end
      end
      if (cmd.q_load) begin
         best_in = $signed({1'b0, max_distance});
      end else if (cmd.eval && !miss && tnear <= tfar && tnear < best_ff) begin
         best_in = tnear;
      end
   end

   assign rsp_data = rsp_ff;

endmodule

### design/rbnh_ctrl.sv
`timescale 1ns / 1ps
module rbnh_ctrl (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   input  logic                              req_is_query,
   output logic                              req_stall,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   input  logic [rbnh_pkg::CNT_W-1:0]        obstacle_count,
   input  rbnh_pkg::status_type              status,
   output rbnh_pkg::cmd_type                 cmd
);
   localparam int CW = rbnh_pkg::CNT_W;
   localparam logic [CW-1:0] BOXES = CW'(rbnh_pkg::MAX_BOXES);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_READ   = 3'd1;
   localparam logic [2:0] ST_START  = 3'd2;
   localparam logic [2:0] ST_WAIT   = 3'd3;
   localparam logic [2:0] ST_EVAL   = 3'd4;
   localparam logic [2:0] ST_FINISH = 3'd5;

   logic [2:0]    state_ff, state_in;
   logic [CW-1:0] idx_ff, idx_in;
   logic [CW-1:0] n_ff, n_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [CW-1:0] n_clamp;
   logic          accept;

   assign n_clamp   = (obstacle_count > BOXES) ? BOXES : obstacle_count;
   assign accept    = req_valid && (state_ff == ST_IDLE);
   assign req_stall = (state_ff != ST_IDLE);

   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      n_in         = n_ff;
      cmd          = '0;
      cmd.rd_addr  = idx_ff[rbnh_pkg::IDX_W-1:0];
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_is_query) begin
                  cmd.q_load = 1'b1;
                  n_in       = n_clamp;
                  idx_in     = '0;
                  state_in   = (n_clamp == '0) ? ST_FINISH : ST_READ;
               end else begin
                  cmd.wr_en = 1'b1;
               end
            end
         end
         ST_READ: begin
            cmd.rd_en = 1'b1;
            state_in  = ST_START;
         end
         ST_START: begin
            cmd.div_start = 1'b1;
            state_in      = ST_WAIT;
         end
         ST_WAIT: begin
            if (!status.div_busy) begin
               state_in = ST_EVAL;
            end
         end
         ST_EVAL: begin
            cmd.eval = 1'b1;
            idx_in   = idx_ff + 1'b1;
            state_in = (idx_ff + 1'b1 == n_ff) ? ST_FINISH : ST_READ;
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.out_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         idx_ff       <= '0;
         n_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         n_ff         <= n_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      cmd.div_start |=> status.div_busy)
      else $error("divider not busy after start");

   a_load_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |=> rsp_valid_ff)
      else $error("result not presented after load");

   a_idx_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WAIT) |-> (idx_ff < n_ff))
      else $error("box index past count");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall) |-> !cmd.out_load)
      else $error("waiting result overwritten");

endmodule

### design/ray_box_nearest_hit.sv
`timescale 1ns / 1ps
// Nearest ray hit against a table of up to 64 axis-aligned boxes, all values
// signed Q12.12. A write item (req_type 0) loads one box from its x/z centre,
// x/z half extents and top height (vec_y) and gives no result. A query item
// (req_type 1) runs the slab test against entries 0 to obstacle_count-1
// (at most 63) and returns one item with the nearest hit distance
// (max_distance if nothing is hit) and a hit flag. For each box six
// shift-subtract dividers run 26 steps side by side to form the saturated
// slab times. Table entries are not cleared at reset; query only boxes that
// have been written. Write the configuration registers only while the block
// is idle.
module ray_box_nearest_hit (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  rbnh_pkg::req_item_type            req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output rbnh_pkg::rsp_item_type            rsp_data,
   input  logic                              csr_wr_en,
   input  logic                              csr_index,
   input  logic [rbnh_pkg::DIST_W-1:0]       csr_wdata
);
   logic [rbnh_pkg::CNT_W-1:0]  count_ff;
   logic [rbnh_pkg::DIST_W-1:0] maxd_ff;
   rbnh_pkg::cmd_type           cmd;
   rbnh_pkg::status_type        status;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         maxd_ff  <= rbnh_pkg::MAX_DISTANCE_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            rbnh_pkg::CSR_OBSTACLE_COUNT: count_ff <= csr_wdata[rbnh_pkg::CNT_W-1:0];
            rbnh_pkg::CSR_MAX_DISTANCE:   maxd_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   rbnh_ctrl u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_is_query   (req_data.req_type == rbnh_pkg::REQ_QUERY),
      .req_stall      (req_stall),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .obstacle_count (count_ff),
      .status         (status),
      .cmd            (cmd)
   );

   rbnh_datapath u_datapath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .req_data     (req_data),
      .max_distance (maxd_ff),
      .status       (status),
      .rsp_data     (rsp_data)
   );

endmodule

### bench/testbench.sv
`timescale 1ns / 1ps
module testbench;

   localparam int   Q_ONE      = 4096;   // 1.0 in Q12.12
   localparam int   IDLE_LIMIT = 20000;  // a 64-box query plus stalls fits well inside
   localparam int   SETTLE_CYC = 40;
   localparam int   REQ_W      = $bits(rbnh_pkg::req_item_type);
   localparam int   QW         = rbnh_pkg::Q_W;
   localparam int   DW         = rbnh_pkg::DIST_W;
   localparam int   NBOX       = rbnh_pkg::MAX_BOXES;
   localparam logic [DW-1:0] DIST_MAX = 23'h7FFFFF;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   rbnh_pkg::req_item_type req_data = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   rbnh_pkg::rsp_item_type rsp_data;
   logic                   csr_wr_en = 1'b0;
   logic                   csr_index = rbnh_pkg::CSR_OBSTACLE_COUNT;
   logic [DW-1:0]          csr_wdata = '0;

   ray_box_nearest_hit dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_wr_en(csr_wr_en), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Shadow copy of the box table and the registers, updated as items are accepted.
   logic signed [QW-1:0] box_lo_x [NBOX];
   logic signed [QW-1:0] box_hi_x [NBOX];
   logic signed [QW-1:0] box_lo_z [NBOX];
   logic signed [QW-1:0] box_hi_z [NBOX];
   logic signed [QW-1:0] box_top  [NBOX];
   int unsigned          boxes_used = 0;
   logic [DW-1:0]        far_limit  = rbnh_pkg::MAX_DISTANCE_RESET;

   rbnh_pkg::rsp_item_type hits_due [$];   // expected hits, oldest first
   int                     errors = 0;

   function automatic longint clamp_q(longint v);
      if (v > 64'sd8388607) return 64'sd8388607;
      if (v < -64'sd8388608) return -64'sd8388608;
      return v;
   endfunction

   // Slab test of the ray against every box in use; keep the nearest entry distance.
   function automatic rbnh_pkg::rsp_item_type nearest_hit(rbnh_pkg::req_item_type r);
      longint o [3], d [3], lo [3], hi [3];
      longint best, tn, tf, t1, t2, s;
      int     n;
      bit     miss;
      rbnh_pkg::rsp_item_type res;
      o[0] = $signed(r.pos_x); o[1] = $signed(r.pos_y); o[2] = $signed(r.pos_z);
      d[0] = $signed(r.vec_x); d[1] = $signed(r.vec_y); d[2] = $signed(r.vec_z);
      best = far_limit;
      n = (boxes_used > NBOX) ? NBOX : int'(boxes_used);
      for (int i = 0; i < n; i++) begin
         lo[0] = box_lo_x[i]; lo[1] = 0;          lo[2] = box_lo_z[i];
         hi[0] = box_hi_x[i]; hi[1] = box_top[i]; hi[2] = box_hi_z[i];
         tn = 0;
         tf = far_limit;
         miss = 1'b0;
         for (int a = 0; a < 3 && !miss; a++) begin
            if (d[a] == 0) begin
               // parallel axis: miss unless the origin lies inside the slab
               if (o[a] < lo[a] || o[a] > hi[a]) miss = 1'b1;
            end else begin
               t1 = clamp_q(((lo[a] - o[a]) * Q_ONE) / d[a]);
               t2 = clamp_q(((hi[a] - o[a]) * Q_ONE) / d[a]);
               if (t1 > t2) begin
                  s = t1; t1 = t2; t2 = s;
               end
               if (t1 > tn) tn = t1;
               if (t2 < tf) tf = t2;
               if (tn > tf) miss = 1'b1;
            end
         end
         if (!miss && tn < best) best = tn;
      end
      res.hit_distance = best[DW-1:0];
      res.hit_found    = (best < longint'(far_limit));
      return res;
   endfunction

   task automatic absorb_item(rbnh_pkg::req_item_type r);
      int idx;
      if (r.req_type == rbnh_pkg::REQ_WRITE) begin
         idx = int'(r.entry_index);
         box_lo_x[idx] = 24'(clamp_q(longint'($signed(r.pos_x)) - $signed(r.vec_x)));
         box_hi_x[idx] = 24'(clamp_q(longint'($signed(r.pos_x)) + $signed(r.vec_x)));
         box_lo_z[idx] = 24'(clamp_q(longint'($signed(r.pos_z)) - $signed(r.vec_z)));
         box_hi_z[idx] = 24'(clamp_q(longint'($signed(r.pos_z)) + $signed(r.vec_z)));
         box_top[idx]  = r.vec_y;
      end else begin
         hits_due.push_back(nearest_hit(r));
      end
   endtask

   task automatic report(string what, longint got, longint want);
      $display("mismatch %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
      errors++;
   endtask

   // Sample both handshakes mid-cycle, act on them at the next rising edge.
   logic                   req_take = 1'b0;
   logic                   rsp_take = 1'b0;
   rbnh_pkg::rsp_item_type rsp_seen;
   always @(negedge clock) begin
      req_take = (req_valid === 1'b1) && (req_stall === 1'b0) && !reset;
      rsp_take = (rsp_valid === 1'b1) && (rsp_stall === 1'b0) && !reset;
      rsp_seen = rsp_data;
   end

   // Check each returned item against the oldest expectation.
   rbnh_pkg::rsp_item_type want;
   always @(posedge clock) begin
      if (rsp_take) begin
         if (hits_due.size() == 0) begin
            report("unexpected item", longint'(rsp_seen.hit_distance), -1);
         end else begin
            want = hits_due.pop_front();
            if (rsp_seen.hit_distance !== want.hit_distance)
               report("hit_distance", longint'(rsp_seen.hit_distance),
                      longint'(want.hit_distance));
            if (rsp_seen.hit_found !== want.hit_found)
               report("hit_found", longint'(rsp_seen.hit_found), longint'(want.hit_found));
         end
      end
   end

   // Watchdog: end the run if nothing moves for too long.
   int idle_cycles = 0;
   always @(posedge clock) begin
      if (req_take || rsp_take || reset) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // Receiver: cycle through no stall, random stall and long stall runs.
   int stall_mode = 0, stall_left = 0, mode_left = 0;
   always @(posedge clock) begin
      if (mode_left == 0) begin
         stall_mode = $urandom_range(0, 2);
         mode_left  = $urandom_range(50, 400);
      end else begin
         mode_left--;
      end
      case (stall_mode)
         0: rsp_stall <= 1'b0;
         1: rsp_stall <= 1'($urandom_range(0, 1));
         default: begin
            if (stall_left == 0) stall_left = $urandom_range(0, 1) ? $urandom_range(1, 20) : 0;
            else stall_left--;
            rsp_stall <= (stall_left != 0);
         end
      endcase
   end

   // Sender: bursts of random length with random gaps between them.
   int burst_left = 0;
   bit gaps_on    = 1'b1;
   task automatic send_item(rbnh_pkg::req_item_type r);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         gap = gaps_on ? $urandom_range(0, 15) : 0;
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (!req_take);
      absorb_item(r);
   endtask

   // Hold off until every expected item is back and the block has gone quiet.
   task automatic drain_block();
      req_valid <= 1'b0;
      while (hits_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYC) @(posedge clock);
   endtask

   task automatic write_csr(logic idx, logic [DW-1:0] val);
      drain_block();
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      if (idx == rbnh_pkg::CSR_OBSTACLE_COUNT) boxes_used = 32'(val[6:0]);
      else far_limit = val;
   endtask

   function automatic logic signed [QW-1:0] near_q(int span);
      return 24'($signed(24'($urandom_range(0, 2 * span * Q_ONE))) - span * Q_ONE);
   endfunction

   function automatic rbnh_pkg::req_item_type make_box(int idx);
      rbnh_pkg::req_item_type r;
      r = REQ_W'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
      r.req_type    = rbnh_pkg::REQ_WRITE;
      r.entry_index = 6'(idx);
      if ($urandom_range(0, 9) != 0) begin
         r.pos_x = near_q(64);
         r.pos_z = near_q(64);
         r.vec_x = 24'($urandom_range(0, 8 * Q_ONE));
         r.vec_z = 24'($urandom_range(0, 8 * Q_ONE));
         r.vec_y = 24'($urandom_range(0, 8 * Q_ONE));
         if ($urandom_range(0, 15) == 0) r.vec_x = -r.vec_x;   // inverted box
      end
      return r;
   endfunction

   function automatic rbnh_pkg::req_item_type make_ray();
      rbnh_pkg::req_item_type r;
      r = REQ_W'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
      r.req_type = rbnh_pkg::REQ_QUERY;
      if ($urandom_range(0, 9) != 0) begin
         r.pos_x = near_q(80);
         r.pos_y = 24'($urandom_range(0, 10 * Q_ONE));
         r.pos_z = near_q(80);
         r.vec_x = near_q(4);
         r.vec_y = near_q(1);
         r.vec_z = near_q(4);
         // parallel axes
         if ($urandom_range(0, 3) == 0) r.vec_y = '0;
         if ($urandom_range(0, 5) == 0) r.vec_x = '0;
         if ($urandom_range(0, 5) == 0) r.vec_z = '0;
      end
      return r;
   endfunction

   function automatic rbnh_pkg::req_item_type box_row(int idx, int cx, int cz, int hx,
                                                      int hz, int top);
      rbnh_pkg::req_item_type r;
      r = '0;
      r.req_type = rbnh_pkg::REQ_WRITE; r.entry_index = 6'(idx);
      r.pos_x = 24'(cx); r.pos_z = 24'(cz); r.vec_x = 24'(hx); r.vec_z = 24'(hz);
      r.vec_y = 24'(top);
      return r;
   endfunction

   function automatic rbnh_pkg::req_item_type ray_row(int ox, int oy, int oz, int dx,
                                                      int dy, int dz);
      rbnh_pkg::req_item_type r;
      r = '0;
      r.req_type = rbnh_pkg::REQ_QUERY;
      r.pos_x = 24'(ox); r.pos_y = 24'(oy); r.pos_z = 24'(oz);
      r.vec_x = 24'(dx); r.vec_y = 24'(dy); r.vec_z = 24'(dz);
      return r;
   endfunction

   typedef struct {
      bit                     is_csr;
      logic                   csr_sel;
      logic [DW-1:0]          csr_val;
      rbnh_pkg::req_item_type item;
      bit                     fixed;   // expected item typed in below
      rbnh_pkg::rsp_item_type result;
   } step_row_type;

   step_row_type steps [$];
   int           qmin, qmax, big_phase, count_pick;

   initial begin
      qmin = -8388608;
      qmax = 8388607;
      // Directed table: boxes 0 to 3 and 63, then rays over extremes and parallel axes.
      steps.push_back('{0, 0, 0, ray_row(0, 0, 0, Q_ONE, 0, 0), 1,
                        '{rbnh_pkg::MAX_DISTANCE_RESET, 1'b0}});
      steps.push_back('{0, 0, 0, box_row(0, 10 * Q_ONE, 0, Q_ONE, Q_ONE, 2 * Q_ONE), 0, '0});
      steps.push_back('{0, 0, 0, box_row(1, qmax, qmin, qmax, qmax, qmax), 0, '0});
      steps.push_back('{0, 0, 0, box_row(2, 0, 0, -2 * Q_ONE, Q_ONE, -Q_ONE), 0, '0});
      steps.push_back('{0, 0, 0, box_row(3, 0, 20 * Q_ONE, Q_ONE, Q_ONE, 2 * Q_ONE), 0, '0});
      steps.push_back('{0, 0, 0, box_row(63, qmin, qmax, qmax, qmax, qmax), 0, '0});
      steps.push_back('{1, rbnh_pkg::CSR_OBSTACLE_COUNT, 4, '0, 0, '0});
      steps.push_back('{0, 0, 0, ray_row(0, Q_ONE, 0, Q_ONE, 0, 0), 0, '0});
      steps.push_back('{0, 0, 0, ray_row(10 * Q_ONE, Q_ONE, 0, 0, 0, 0), 0, '0});
      steps.push_back('{0, 0, 0, ray_row(0, Q_ONE, 0, -Q_ONE, 0, 0), 0, '0});
      steps.push_back('{0, 0, 0, ray_row(0, Q_ONE, 0, 0, 0, Q_ONE), 0, '0});
      steps.push_back('{0, 0, 0, ray_row(0, 3 * Q_ONE, 0, Q_ONE, -Q_ONE / 4, Q_ONE), 0, '0});
      steps.push_back('{0, 0, 0, ray_row(qmin, qmin, qmin, qmax, qmax, qmax), 0, '0});
      steps.push_back('{0, 0, 0, ray_row(qmax, qmax, qmax, qmin, qmin, qmin), 0, '0});
      steps.push_back('{0, 0, 0, ray_row(0, Q_ONE, 0, 1, 0, -1), 0, '0});
      steps.push_back('{1, rbnh_pkg::CSR_MAX_DISTANCE, 0, '0, 0, '0});
      steps.push_back('{0, 0, 0, ray_row(10 * Q_ONE, Q_ONE, 0, Q_ONE, 0, 0), 0, '0});
      steps.push_back('{1, rbnh_pkg::CSR_MAX_DISTANCE, DIST_MAX, '0, 0, '0});
      steps.push_back('{0, 0, 0, ray_row(0, Q_ONE, 0, Q_ONE, 0, 0), 0, '0});
      steps.push_back('{0, 0, 0, ray_row(-Q_ONE, 0, qmin, 0, 0, qmax), 0, '0});
      steps.push_back('{0, 0, 0, ray_row(-1, -1, -1, -1, 1, -1), 0, '0});

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (steps[i]) begin
         if (steps[i].is_csr) begin
            write_csr(steps[i].csr_sel, steps[i].csr_val);
         end else begin
            send_item(steps[i].item);
            // swap the predicted item for the one read off by hand
            if (steps[i].fixed) hits_due[$] = steps[i].result;
         end
      end

      // Fill the whole table so that any count is safe from here on.
      for (int i = 0; i < NBOX; i++) send_item(make_box(i));

      big_phase = $urandom_range(0, 15);
      for (int ph = 0; ph < 16; ph++) begin
         gaps_on = (ph % 4 != 3);
         if (ph == big_phase)  count_pick = NBOX;
         else if (ph == 15)    count_pick = 127;   // above the table size
         else if (ph == 7)     count_pick = 0;
         else                  count_pick = $urandom_range(1, 8);
         write_csr(rbnh_pkg::CSR_OBSTACLE_COUNT, 23'(count_pick));
         case (ph % 5)
            0: write_csr(rbnh_pkg::CSR_MAX_DISTANCE, rbnh_pkg::MAX_DISTANCE_RESET);
            1: write_csr(rbnh_pkg::CSR_MAX_DISTANCE, 23'($urandom_range(0, 200 * Q_ONE)));
            2: write_csr(rbnh_pkg::CSR_MAX_DISTANCE, DIST_MAX);
            3: write_csr(rbnh_pkg::CSR_MAX_DISTANCE, 23'($urandom_range(0, 4 * Q_ONE)));
            default: write_csr(rbnh_pkg::CSR_MAX_DISTANCE, 23'($urandom));
         endcase
         for (int k = 0; k < ((count_pick >= NBOX) ? 40 : 100); k++) begin
            if (k == 50) drain_block();   // pause until everything is back
            if ($urandom_range(0, 9) < 3) send_item(make_box($urandom_range(0, NBOX - 1)));
            else send_item(make_ray());
         end
      end

      drain_block();
      if (errors == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

### ray_box_nearest_hit.f
design/rbnh_pkg.sv
design/rbnh_div.sv
design/rbnh_datapath.sv
design/rbnh_ctrl.sv
design/ray_box_nearest_hit.sv
bench/testbench.sv
